>>> rtl/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, held off during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every clock, including during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/rgb_hls_pkg.sv
// ----------------------------------------------------------------------------
// rgb_hls_pkg
// shared types and constants of the rgb to hls converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgb_hls_pkg;

  localparam int LEVEL_MAX_DEF = 255;
  localparam int CH_W          = 8;
  localparam int NUM_W         = 16;
  localparam int DEN_W         = 9;
  localparam int HUE_W         = 11;

  localparam logic [1:0] MAX_RED   = 2'd0;
  localparam logic [1:0] MAX_GREEN = 2'd1;
  localparam logic [1:0] MAX_BLUE  = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] lightness;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] hue;
  } hls_t;

  typedef struct packed {
    logic            grey;
    logic            sat_full;
    logic [1:0]      max_sel;
    logic [CH_W-1:0] light;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [NUM_W-1:0]   sat_num;
    logic [DEN_W-1:0]   sat_den;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   g_num;
    logic [NUM_W-1:0]   b_num;
    logic [DEN_W-1:0]   hue_den;
  } work_t;

endpackage

>>> rtl/rgb_to_hls_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hls_converter
// integer rgb to hue, lightness, saturation conversion of a pixel stream
// ----------------------------------------------------------------------------
//   channel   direction  handshake                      payload
//   pixel     in         pixel_valid / pixel_ready      pixel_t  (red, green, blue)
//   result    out        result_valid / result_ready    hls_t    (lightness, saturation, hue)
//
// one pixel accepted per clock when the output is taken
// path: front register, queue, 16 divider stages, result register
// the 16-stage divider pipeline sets the latency; its four lanes run in lockstep
// reset clears only valid flags, queue pointers and the queue count
// a stalled result freezes the back part; the queue lets the front take two more requests
`timescale 1ns / 1ps

module rgb_to_hls_converter
  import rgb_hls_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   result_valid,
  input  logic   result_ready,
  output hls_t   result
);

  // front to queue
  logic  fq_valid, fq_ready;
  work_t fq_data;
  // queue to back
  logic  qb_valid, qb_ready;
  work_t qb_data;

  // classify: max, min, lightness and divider operands
  rgb_hls_front #(.LEVEL_MAX(LEVEL_MAX)) u_front (
    .clk, .rst,
    .pixel_valid, .pixel_ready, .pixel,
    .work_valid(fq_valid), .work_ready(fq_ready), .work(fq_data)
  );

  // decouples the front from back-end stalls
  rgb_hls_queue u_queue (
    .clk, .rst,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
  );

  // divisions, hue wrap and output register
  rgb_hls_back #(.LEVEL_MAX(LEVEL_MAX)) u_back (
    .clk, .rst,
    .work_valid(qb_valid), .work_ready(qb_ready), .work(qb_data),
    .result_valid, .result_ready, .result
  );

endmodule

>>> rtl/rgb_hls_front.sv
// ----------------------------------------------------------------------------
// rgb_hls_front
// takes pixels, finds max and min, sets up divider operands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hls_front
  import rgb_hls_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   work_valid,
  input  logic   work_ready,
  output work_t  work
);

  localparam int HALF  = LEVEL_MAX / 2;
  localparam int SIXTH = LEVEL_MAX / 6;
  localparam int TWO_M = 2 * LEVEL_MAX;

  logic [CH_W-1:0]  cmax, cmin, spread, light;
  logic [8:0]       sum;
  logic [9:0]       sum_inc, two_m_diff;
  logic             light_low, sat_full;
  logic [DEN_W-1:0] sat_den;
  logic [NUM_W-1:0] sat_prod, r_prod, g_prod, b_prod;
  logic [1:0]       max_sel;
  work_t            work_next;

  assign pixel_ready = !work_valid || work_ready;

  always_comb begin
    cmax = pixel.red;
    cmin = pixel.red;
    if (pixel.green > cmax) cmax = pixel.green;
    if (pixel.blue > cmax) cmax = pixel.blue;
    if (pixel.green < cmin) cmin = pixel.green;
    if (pixel.blue < cmin) cmin = pixel.blue;
    spread  = cmax - cmin;
    sum     = {1'b0, cmax} + {1'b0, cmin};
    // (sum*M + M) / 2M reduces to (sum + 1) / 2
    sum_inc = {1'b0, sum} + 10'd1;
    light   = sum_inc[8:1];

    light_low  = light <= CH_W'(HALF);
    two_m_diff = 10'(TWO_M) - {1'b0, sum};
    sat_full   = !light_low && ({1'b0, sum} >= 10'(TWO_M));
    if (light_low) begin
      sat_den = sum;
    end else if (sat_full) begin
      sat_den = DEN_W'(1);
    end else begin
      sat_den = two_m_diff[DEN_W-1:0];
    end

    sat_prod = NUM_W'(spread) * NUM_W'(LEVEL_MAX);
    r_prod   = NUM_W'(cmax - pixel.red) * NUM_W'(SIXTH);
    g_prod   = NUM_W'(cmax - pixel.green) * NUM_W'(SIXTH);
    b_prod   = NUM_W'(cmax - pixel.blue) * NUM_W'(SIXTH);

    if (pixel.red == cmax) begin
      max_sel = MAX_RED;
    end else if (pixel.green == cmax) begin
      max_sel = MAX_GREEN;
    end else begin
      max_sel = MAX_BLUE;
    end

    // half the divisor added up front gives round half up
    work_next.side.grey     = spread == '0;
    work_next.side.sat_full = sat_full;
    work_next.side.max_sel  = max_sel;
    work_next.side.light    = light;
    work_next.sat_num       = sat_prod + NUM_W'(sat_den >> 1);
    work_next.sat_den       = sat_den;
    work_next.r_num         = r_prod + NUM_W'(spread >> 1);
    work_next.g_num         = g_prod + NUM_W'(spread >> 1);
    work_next.b_num         = b_prod + NUM_W'(spread >> 1);
    work_next.hue_den       = {1'b0, spread};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (pixel_ready) begin
      work_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_ready && pixel_valid) begin
      work <= work_next;
    end
  end

endmodule

>>> rtl/rgb_hls_queue.sv
// ----------------------------------------------------------------------------
// rgb_hls_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hls_queue
  import rgb_hls_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  work_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output work_t out_data
);

  work_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

endmodule

>>> rtl/rgb_hls_div.sv
// ----------------------------------------------------------------------------
// rgb_hls_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hls_div
  import rgb_hls_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem_s [NUM_W];
  logic [NUM_W-1:0] num_s [NUM_W];
  logic [NUM_W-1:0] quo_s [NUM_W];
  logic [DEN_W-1:0] den_s [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in, den_in;
    logic [NUM_W-1:0] num_in, quo_in;
    logic [DEN_W:0]   trial, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_s[k-1];
      assign num_in = num_s[k-1];
      assign quo_in = quo_s[k-1];
      assign den_in = den_s[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_s[k] <= num_in << 1;
        quo_s[k] <= {quo_in[NUM_W-2:0], ge};
        den_s[k] <= den_in;
      end
    end
  end

  assign quo = quo_s[NUM_W-1];

endmodule

>>> rtl/rgb_hls_back.sv
// ----------------------------------------------------------------------------
// rgb_hls_back
// divider lanes, hue wrap and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hls_back
  import rgb_hls_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  work_valid,
  output logic  work_ready,
  input  work_t work,
  output logic  result_valid,
  input  logic  result_ready,
  output hls_t  result
);

  localparam int THIRD      = LEVEL_MAX / 3;
  localparam int TWO_THIRDS = (2 * LEVEL_MAX) / 3;

  logic             advance;
  logic             vld    [NUM_W];
  side_t            side_s [NUM_W];
  logic [NUM_W-1:0] q_sat, q_r, q_g, q_b;
  side_t            side_o;
  logic [CH_W-1:0]  d_a, d_b;
  logic signed [HUE_W-1:0] hue_s;
  hls_t             result_next;

  assign advance    = !result_valid || result_ready;
  assign work_ready = advance;

  rgb_hls_div u_div_sat (.clk, .en(advance), .num(work.sat_num), .den(work.sat_den), .quo(q_sat));
  rgb_hls_div u_div_r   (.clk, .en(advance), .num(work.r_num), .den(work.hue_den), .quo(q_r));
  rgb_hls_div u_div_g   (.clk, .en(advance), .num(work.g_num), .den(work.hue_den), .quo(q_g));
  rgb_hls_div u_div_b   (.clk, .en(advance), .num(work.b_num), .den(work.hue_den), .quo(q_b));

  for (genvar k = 0; k < NUM_W; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (advance) begin
        vld[k] <= (k == 0) ? work_valid : vld[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        side_s[k] <= (k == 0) ? work.side : side_s[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign side_o = side_s[NUM_W-1];

  always_comb begin
    case (side_o.max_sel)
      MAX_RED: begin
        hue_s = '0;
        d_a   = q_b[CH_W-1:0];
        d_b   = q_g[CH_W-1:0];
      end
      MAX_GREEN: begin
        hue_s = HUE_W'(THIRD);
        d_a   = q_r[CH_W-1:0];
        d_b   = q_b[CH_W-1:0];
      end
      default: begin
        hue_s = HUE_W'(TWO_THIRDS);
        d_a   = q_g[CH_W-1:0];
        d_b   = q_r[CH_W-1:0];
      end
    endcase
    hue_s = hue_s + $signed({3'b000, d_a}) - $signed({3'b000, d_b});
    if (hue_s < 0) hue_s = hue_s + HUE_W'(LEVEL_MAX);
    if (hue_s > HUE_W'(LEVEL_MAX)) hue_s = hue_s - HUE_W'(LEVEL_MAX);
    if (hue_s > HUE_W'(255)) hue_s = HUE_W'(255);

    result_next.lightness = side_o.light;
    if (side_o.grey) begin
      result_next.saturation = '0;
      result_next.hue        = CH_W'(TWO_THIRDS);
    end else begin
      if (side_o.sat_full) begin
        result_next.saturation = CH_W'(LEVEL_MAX);
      end else if (q_sat[NUM_W-1:CH_W] != '0) begin
        result_next.saturation = '1;
      end else begin
        result_next.saturation = q_sat[CH_W-1:0];
      end
      result_next.hue = hue_s[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= vld[NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= result_next;
  end

endmodule

>>> rtl/rgb_hls_checker.sv
// ----------------------------------------------------------------------------
// rgb_hls_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_hls_checker
  import rgb_hls_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input logic   clk,
  input logic   rst,
  input logic   pixel_valid,
  input logic   pixel_ready,
  input logic   result_valid,
  input logic   result_ready,
  input hls_t   result
);

  // nothing comes out straight after reset
  `ASSERT_ALWAYS(a_reset_idle, rst |=> !result_valid, "result valid after reset")
  // a stalled result holds
  `ASSERT_CLK(a_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")
  // wrapped hue stays on the scale
  `ASSERT_CLK(a_hue_range, result_valid |-> result.hue <= 8'(LEVEL_MAX), "hue beyond scale")
  // a newly offered pixel is never blocked while the output is empty
  `ASSERT_CLK(a_in_ready, !result_valid |-> pixel_ready || !pixel_valid || $past(pixel_valid), "input blocked with empty output")

endmodule

bind rgb_to_hls_converter rgb_hls_checker #(.LEVEL_MAX(LEVEL_MAX)) u_checker (
  .clk(clk), .rst(rst),
  .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
  .result_valid(result_valid), .result_ready(result_ready), .result(result)
);

>>> sim/tb_rgb_to_hls_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hls_converter
// self-checking bench: pixels are sent over the valid/ready channel, each
// result is compared with a behavioural prediction of the hls conversion
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_to_hls_converter;
  import rgb_hls_pkg::*;

  localparam int LVL         = LEVEL_MAX_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 40;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_ready;
  pixel_t pixel = '0;
  logic   result_valid;
  logic   result_ready = 1'b0;
  hls_t   result;

  hls_t   hls_expected_q[$];
  int     mismatch_count = 0;
  int     result_count = 0;
  int     cycle_count = 0;
  int     send_idle_pct = 36;   // idle percentage for the sender
  int     recv_idle_pct = 36;   // idle percentage for the receiver
  int     hold_off_cycles = 0;  // receiver long stall, counted below

  always #1 clk = ~clk;

  rgb_to_hls_converter uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // rounded division, half up
  function automatic longint round_div(longint n, longint d);
    return (n + d / 2) / d;
  endfunction

  function automatic logic [7:0] clamp_to_byte(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // predicted hls of one pixel
  function automatic hls_t hls_of_pixel(pixel_t p);
    longint r, g, b, cmax, cmin, light, sat, hue, spread, sum, den, rd, gd, bd;
    hls_t   h;
    r = longint'(p.red);
    g = longint'(p.green);
    b = longint'(p.blue);
    cmax = r;
    cmin = r;
    if (g > cmax) cmax = g;
    if (b > cmax) cmax = b;
    if (g < cmin) cmin = g;
    if (b < cmin) cmin = b;
    light = ((cmax + cmin) * LVL + LVL) / (2 * LVL);
    if (cmax == cmin) begin
      sat = 0;
      hue = (LVL * 2) / 3;
    end else begin
      spread = cmax - cmin;
      sum = cmax + cmin;
      if (light <= LVL / 2) begin
        sat = round_div(spread * LVL, sum);
      end else begin
        den = 2 * LVL - sum;
        sat = (den > 0) ? round_div(spread * LVL, den) : LVL;
      end
      rd = round_div((cmax - r) * (LVL / 6), spread);
      gd = round_div((cmax - g) * (LVL / 6), spread);
      bd = round_div((cmax - b) * (LVL / 6), spread);
      if (r == cmax) hue = bd - gd;
      else if (g == cmax) hue = LVL / 3 + rd - bd;
      else hue = (2 * LVL) / 3 + gd - rd;
      if (hue < 0) hue += LVL;
      if (hue > LVL) hue -= LVL;
    end
    h.lightness  = clamp_to_byte(light);
    h.saturation = clamp_to_byte(sat);
    h.hue        = clamp_to_byte(hue);
    return h;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, hls_expected_q.size());
      $display("FAIL rgb_to_hls_converter");
      $finish;
    end
  end

  // receiver: random back-pressure, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    hls_t exp_hls;
    if (!rst && result_valid && result_ready) begin
      result_count++;
      if (hls_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result l=%0d s=%0d h=%0d", result.lightness,
                   result.saturation, result.hue);
      end else begin
        exp_hls = hls_expected_q.pop_front();
        if (result.lightness !== exp_hls.lightness ||
            result.saturation !== exp_hls.saturation || result.hue !== exp_hls.hue) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected l=%0d s=%0d h=%0d, got l=%0d s=%0d h=%0d",
                     exp_hls.lightness, exp_hls.saturation, exp_hls.hue,
                     result.lightness, result.saturation, result.hue);
        end
      end
    end
  end

  // send one pixel request, with a random idle gap in front of it;
  // valid stays up after acceptance until the next request or an idle cycle
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pixel_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    p.red = r;
    p.green = g;
    p.blue = b;
    pixel_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    hls_expected_q.push_back(hls_of_pixel(p));
  endtask

  task automatic wait_for_results();
    pixel_valid <= 1'b0;
    while (hls_expected_q.size() != 0) @(posedge clk);
  endtask

  // extremes, grey pixels, each channel as largest, ties, bright and dark side
  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd100); // red largest, hue goes negative and wraps
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd254); // bright side, small divisor
    send_pixel(8'd1, 8'd0, 8'd0);       // dark side, small divisor
    send_pixel(8'd127, 8'd128, 8'd127);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50, 8'd200, 8'd100);
    send_pixel(8'd100, 8'd50, 8'd200);
    send_pixel(8'd170, 8'd85, 8'd85);
    send_pixel(8'd85, 8'd170, 8'd170);
    send_pixel(8'd1, 8'd2, 8'd4);
    send_pixel(8'd254, 8'd253, 8'd251);
  endtask

  // random pixels, partly grey or with tied channels
  task automatic test_random(input int count);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      r = 8'($urandom_range(255));
      g = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
      case ($urandom_range(9))
        0: begin g = r; b = r; end
        1: g = r;
        2: b = g;
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  // back-to-back stream with no idling on either side
  task automatic test_full_rate(input int count);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(count);
    send_idle_pct = 36;
    recv_idle_pct = 36;
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    wait_for_results();
    @(posedge clk);
    hold_off_cycles <= 120;
    send_idle_pct = 0;
    test_random(60);
    send_idle_pct = 36;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_for_results();   // sender pauses until everything is back
    test_random(250);
    test_full_rate(150);
    test_backpressure();
    test_random(120);
    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered directed extremes, grey and tied pixels, random pixels,");
    $display("full-rate streaming and a long output stall: %0d results checked",
             result_count);
    if (mismatch_count == 0 && hls_expected_q.size() == 0) begin
      $display("PASS rgb_to_hls_converter");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL rgb_to_hls_converter");
    end
    $finish;
  end

endmodule
